>>> rtl/tmls_pkg.sv
// ----------------------------------------------------------------------------
// tmls_pkg: shared types and constants of the top-M largest selection core
// Holds the payload structs, the controller-datapath command and status
// structs, and the fixed field widths.
// ----------------------------------------------------------------------------
package tmls_pkg;

  localparam int unsigned ValueW         = 32;
  localparam int unsigned CountW         = 5;
  localparam int unsigned MaxKeptDefault = 16;
  localparam int unsigned ResultLimit    = 16;

  localparam logic [CountW-1:0] CountReset = CountW'(1);

  localparam logic StatusOk     = 1'b0;
  localparam logic StatusTooFew = 1'b1;

  typedef struct packed {
    logic signed [ValueW-1:0] sample_value;
    logic                     is_final;
  } tmls_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] top_value;
    logic                     end_of_run;
    logic                     status;
  } tmls_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;      // insert the incoming sample into the sorted row
    logic emit;        // load the head of the row into the output register, shift up
    logic last;        // flag the emitted result as the final one of the run
    logic load_error;  // load the too-few-items result
    logic clear;       // empty the row
  } tmls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a new result this cycle
  } tmls_status_t;

endpackage

>>> rtl/tmls_datapath.sv
// ----------------------------------------------------------------------------
// tmls_datapath: sorted cell row and output register
// A row of cells keeps the largest values in descending order; an insert
// compares every cell in parallel and shifts the tail down by one place.
// ----------------------------------------------------------------------------
module tmls_datapath #(
  parameter int unsigned MaxKept = tmls_pkg::MaxKeptDefault,
  parameter int unsigned FillW   = $clog2(MaxKept + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tmls_pkg::tmls_cmd_t       cmd_i,
  input  logic signed [tmls_pkg::ValueW-1:0] sample_i,
  input  logic                      out_stall_i,
  output tmls_pkg::tmls_status_t    status_o,
  output logic [FillW-1:0]          fill_o,
  output logic                      out_valid_o,
  output tmls_pkg::tmls_out_t       out_data_o
);
  import tmls_pkg::*;

  logic signed [ValueW-1:0] kept_q [MaxKept];
  logic [MaxKept-1:0]       ge;
  logic [FillW-1:0]         fill_d, fill_q;
  logic                     out_valid_d, out_valid_q;
  tmls_out_t                out_d, out_q;

  // Cell holds a valid value not below the sample: it stays in place.
  for (genvar i = 0; i < MaxKept; i++) begin : g_cmp
    assign ge[i] = (FillW'(i) < fill_q) && (kept_q[i] >= sample_i);
  end

  for (genvar i = 0; i < MaxKept; i++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.insert && !ge[i]) begin
        if (i == 0) begin
          kept_q[i] <= sample_i;
        end else if (ge[(i == 0) ? 0 : i-1]) begin
          kept_q[i] <= sample_i;
        end else begin
          kept_q[i] <= kept_q[(i == 0) ? 0 : i-1];
        end
      end else if (cmd_i.emit && (i != MaxKept - 1)) begin
        kept_q[i] <= kept_q[(i == MaxKept - 1) ? i : i+1];
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.clear) begin
      fill_d = '0;
    end else if (cmd_i.insert && (fill_q != FillW'(MaxKept))) begin
      fill_d = fill_q + FillW'(1);
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (cmd_i.load_error) begin
      out_valid_d      = 1'b1;
      out_d.top_value  = '0;
      out_d.end_of_run = 1'b1;
      out_d.status     = StatusTooFew;
    end else if (cmd_i.emit) begin
      out_valid_d      = 1'b1;
      out_d.top_value  = kept_q[0];
      out_d.end_of_run = cmd_i.last;
      out_d.status     = StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign fill_o      = fill_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/tmls_ctrl.sv
// ----------------------------------------------------------------------------
// tmls_ctrl: run controller of the top-M largest selection core
// Holds count_wanted, accepts samples, and sequences the result emission
// after the final sample of a run.
// ----------------------------------------------------------------------------
module tmls_ctrl #(
  parameter int unsigned MaxKept = tmls_pkg::MaxKeptDefault,
  parameter int unsigned FillW   = $clog2(MaxKept + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tmls_pkg::CountW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_final_i,
  output logic                          in_stall_o,
  input  tmls_pkg::tmls_status_t        status_i,
  input  logic [FillW-1:0]              fill_i,
  output tmls_pkg::tmls_cmd_t           cmd_o
);
  import tmls_pkg::*;

  localparam int unsigned WantLimit = (MaxKept < ResultLimit) ? MaxKept : ResultLimit;
  localparam int unsigned CmpW      = (FillW > CountW) ? FillW : CountW;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StDecide = 3'b010,
    StEmit   = 3'b100
  } state_e;

  state_e            state_d, state_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] remaining_d, remaining_q;
  logic [CountW-1:0] want;
  logic              accept;
  logic              too_few;

  assign want = (count_q > CountW'(WantLimit)) ? CountW'(WantLimit) : count_q;
  assign too_few = CmpW'(fill_i) < CmpW'(want);

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    remaining_d = remaining_q;
    cmd_o       = '0;
    cmd_o.insert = accept;
    case (state_q)
      StIdle: begin
        if (accept && in_final_i) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (want == '0) begin
          cmd_o.clear = 1'b1;
          state_d     = StIdle;
        end else if (too_few) begin
          if (status_i.out_free) begin
            cmd_o.load_error = 1'b1;
            cmd_o.clear      = 1'b1;
            state_d          = StIdle;
          end
        end else begin
          remaining_d = want;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit  = 1'b1;
          remaining_d = remaining_q - CountW'(1);
          if (remaining_q == CountW'(1)) begin
            cmd_o.last  = 1'b1;
            cmd_o.clear = 1'b1;
            state_d     = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= CountReset;
      remaining_q <= '0;
    end else begin
      state_q     <= state_d;
      remaining_q <= remaining_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  // An emitting controller always has results left to send.
  a_emit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (remaining_q != '0))
    else $error("emit state with no results left");

  // The final sample of a run always leads to the decision step.
  a_final_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_final_i) |=> (state_q == StDecide))
    else $error("final sample did not start result decision");

  // Results and inserts never overlap.
  a_no_insert_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.insert && (cmd_o.emit || cmd_o.load_error || cmd_o.clear)))
    else $error("insert overlaps result or clear");

  // The row is emptied after the last result of a run.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (fill_i == '0))
    else $error("row not empty after last result");

endmodule

>>> rtl/top_m_largest_select_core.sv
// ----------------------------------------------------------------------------
// top_m_largest_select_core: top-M largest selection over a signed stream
// Results: after the final transaction of a run, the first result follows the decide and
// emit states, the too-few error result follows the decide state; output stalls delay both.
// Throughput: one sample per cycle within a run; the run then stalls the input through
// the decide state and one emit per result (count_wanted saturated to MaxKept and to
// ResultLimit), the decide state alone when it is 0 or too few samples came.
// Reset: asynchronous active low; row empty, no result pending, count_wanted = 1.
// ----------------------------------------------------------------------------
module top_m_largest_select_core #(
  parameter int unsigned MaxKept = tmls_pkg::MaxKeptDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: count_wanted
  input  logic                        cfg_we_i,
  input  logic [tmls_pkg::CountW-1:0] cfg_wdata_i,
  // input samples
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tmls_pkg::tmls_in_t          in_data_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tmls_pkg::tmls_out_t         out_data_o
);
  import tmls_pkg::*;

  // Fill count must hold MaxKept itself.
  localparam int unsigned FillW = $clog2(MaxKept + 1);

  tmls_cmd_t        cmd;
  tmls_status_t     status;
  logic [FillW-1:0] fill;

  // Controller: holds count_wanted and sequences each run. It stalls the
  // input side from the cycle after a final transaction until the last result
  // of the run is loaded into the output register; a result that still waits
  // downstream does not block the next run's samples.
  tmls_ctrl #(
    .MaxKept (MaxKept),
    .FillW   (FillW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_final_i  (in_data_i.is_final),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .fill_i      (fill),
    .cmd_o       (cmd)
  );

  // Datapath: sorted row of MaxKept cells with signed compares, one insert per
  // cycle while the input is not stalled, and the output register. Emission reads
  // the head cell and shifts the row up, so results leave largest first.
  tmls_datapath #(
    .MaxKept (MaxKept),
    .FillW   (FillW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_i    (in_data_i.sample_value),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .fill_o      (fill),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> verif/top_m_largest_select_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_m_largest_select_core_tb: self-checking bench for the top-M selector
// Streams runs of signed samples into the core and predicts the descending
// top-count_wanted list of every run. Every result transaction is checked
// field by field against the oldest prediction. Both sides idle at random,
// and one long output hold-off backs the core up into its input.
// ----------------------------------------------------------------------------
module top_m_largest_select_core_tb;
  import tmls_pkg::*;

  localparam int unsigned MaxKept = MaxKeptDefault;
  localparam logic signed [ValueW-1:0] MostNeg = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] MostPos = 32'sh7fff_ffff;
  // Cycles to let the core settle after its last transaction.
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles   = 150;
  localparam int unsigned IdlePercent  = 36;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  tmls_in_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  tmls_out_t         out_data_o;

  // Samples waiting for the driver, and results still owed by the core.
  tmls_in_t  pending_samples[$];
  tmls_out_t expected_results[$];

  // Predictor state: the kept row (descending) and the count register copy.
  logic signed [ValueW-1:0] kept_row[$];
  logic [CountW-1:0]        wanted_count = CountReset;

  int unsigned samples_queued = 0;
  int unsigned samples_taken  = 0;
  int unsigned error_count    = 0;

  // Traffic shaping: steady_flow turns off random idling on both sides;
  // hold_wanted asks the receiver for one long hold-off.
  logic        steady_flow = 1'b0;
  logic        hold_wanted = 1'b0;
  logic        hold_served = 1'b0;
  int unsigned hold_left   = 0;

  top_m_largest_select_core #(
    .MaxKept(MaxKept)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [ValueW-1:0] got,
                                 input logic [ValueW-1:0] wanted);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, wanted);
    error_count++;
  endtask

  // Insert one accepted sample into the predicted row; on the closing sample
  // of a run, queue the results the core owes and empty the row.
  task automatic select_largest(input tmls_in_t item);
    logic signed [ValueW-1:0] v;
    int unsigned              pos;
    int unsigned              take;
    tmls_out_t                res;
    v   = $signed(item.sample_value);
    pos = 0;
    // Equal values stay ahead of the newcomer, so duplicates keep their order.
    while (pos < kept_row.size() && kept_row[pos] >= v) pos++;
    if (pos < MaxKept) begin
      kept_row.insert(pos, v);
      // A full row drops its smallest entry.
      if (kept_row.size() > MaxKept) void'(kept_row.pop_back());
    end
    samples_taken++;
    if (item.is_final) begin
      take = wanted_count;
      if (take > MaxKept) take = MaxKept;
      if (take > ResultLimit) take = ResultLimit;
      if (take != 0) begin
        if (kept_row.size() < take) begin
          // Too few samples: a single error result closes the run.
          res.top_value  = '0;
          res.end_of_run = 1'b1;
          res.status     = StatusTooFew;
          expected_results.push_back(res);
        end else begin
          for (int unsigned k = 0; k < take; k++) begin
            res.top_value  = kept_row[k];
            res.end_of_run = (k + 1 == take);
            res.status     = StatusOk;
            expected_results.push_back(res);
          end
        end
      end
      kept_row.delete();
    end
  endtask

  // Input driver: offer the next pending sample once the previous transaction
  // is gone. A stalled sample is held unchanged, valid is never dropped early.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) select_largest(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_samples.size() != 0 &&
            (steady_flow || $urandom_range(99) >= IdlePercent)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_samples.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall, or one long hold-off counted here so that the
  // core fills up and stalls its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_wanted && !hold_served) begin
      hold_served <= 1'b1;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !steady_flow && ($urandom_range(99) < IdlePercent);
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    tmls_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_data_o.top_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.top_value !== want.top_value)
          report_mismatch("top_value", out_data_o.top_value, want.top_value);
        if (out_data_o.end_of_run !== want.end_of_run)
          report_mismatch("end_of_run", ValueW'(out_data_o.end_of_run),
                          ValueW'(want.end_of_run));
        if (out_data_o.status !== want.status)
          report_mismatch("status", ValueW'(out_data_o.status), ValueW'(want.status));
      end
    end
  end

  task automatic push_sample(input logic signed [ValueW-1:0] v, input logic closing);
    tmls_in_t item;
    item.sample_value = v;
    item.is_final     = closing;
    pending_samples.push_back(item);
    samples_queued++;
  endtask

  // Mix of extremes, near-extremes, small values that repeat, and full range.
  function automatic logic signed [ValueW-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return MostNeg;
      1:       return MostPos;
      2:       return MostNeg + ValueW'($urandom_range(3));
      3:       return MostPos - ValueW'($urandom_range(3));
      4, 5:    return ValueW'(int'($urandom_range(15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Queue whole runs of random length until about `items` samples are queued.
  task automatic queue_runs(input int unsigned items, input int unsigned min_len,
                            input int unsigned max_len);
    int unsigned count;
    int unsigned len;
    count = 0;
    while (count < items) begin
      len = $urandom_range(max_len, min_len);
      for (int unsigned i = 0; i < len; i++) push_sample(pick_sample(), i + 1 == len);
      count += len;
    end
  endtask

  // Wait until every sample is taken and every result has come, then let
  // the core settle.
  task automatic settle();
    do @(negedge clk_i);
    while (samples_taken != samples_queued || expected_results.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write count_wanted; only called while the core is idle.
  task automatic set_count(input logic [CountW-1:0] v);
    @(posedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= v;
    wanted_count = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset count of one, extremes compared without overflow.
    push_sample(MostNeg, 1'b0);
    push_sample(MostPos, 1'b0);
    push_sample(-32'sd1, 1'b1);
    settle();

    // Too few samples for the count.
    set_count(CountW'(3));
    push_sample(32'sd10, 1'b0);
    push_sample(-32'sd5, 1'b1);
    settle();

    // Zero wanted: the run ends silently.
    set_count(CountW'(0));
    push_sample(32'sd42, 1'b1);
    settle();

    // Full row with duplicates, then an eviction, then a dropped sample.
    set_count(CountW'(MaxKept));
    push_sample(MostNeg, 1'b0);
    push_sample(-32'sd1, 1'b0);
    push_sample(32'sd0, 1'b0);
    push_sample(32'sd1, 1'b0);
    push_sample(MostPos, 1'b0);
    push_sample(32'sd7, 1'b0);
    push_sample(32'sd7, 1'b0);
    push_sample(MostNeg + 1, 1'b0);
    push_sample(MostPos - 1, 1'b0);
    repeat (7) push_sample(pick_sample() | 32'sh0000_0100, 1'b0);
    push_sample(32'sd5, 1'b0);
    push_sample(MostNeg, 1'b1);
    settle();

    // Oversized count saturates; run with no idling on either side.
    set_count(CountW'(31));
    steady_flow = 1'b1;
    queue_runs(40, 1, 40);
    settle();
    steady_flow = 1'b0;

    // Leave a run open across a count change.
    set_count(CountW'(5));
    queue_runs(20, 1, 12);
    repeat (3) push_sample(pick_sample(), 1'b0);
    settle();
    set_count(CountW'(2));
    queue_runs(20, 1, 10);
    settle();

    // Long output hold-off while short runs keep coming in.
    set_count(CountW'(4));
    hold_wanted = 1'b1;
    queue_runs(30, 4, 6);
    settle();

    set_count(CountW'(0));
    queue_runs(10, 1, 8);
    settle();

    set_count(CountW'(17));
    queue_runs(15, 10, 20);
    settle();

    set_count(CountW'(1));
    queue_runs(15, 1, 6);
    settle();

    set_count(CountW'(MaxKept));
    queue_runs(15, 12, 20);
    settle();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
